// ----- hdl/perspective_point_projection_macros.svh -----
// Assertion macros used by the projection RTL.
`ifndef PERSPECTIVE_POINT_PROJECTION_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTION_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define PPP_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle check");

// Check that cond holds in the cycle after trig.
`define PPP_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- hdl/ppp_pkg.sv -----
// Constants and types for the perspective point projection block.
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    // Near-zero bound of 1e-6 in LSBs, truncated.
    localparam int W_EPS_LSB   = (1 << FRAC_BITS) / 1000000;
    localparam int CW = COORD_WIDTH;
    localparam int NW = 2 * CW + 1;   // clip magnitude / remainder
    localparam int SW = 2 * CW + 2;   // signed clip sum
    localparam int QB = CW + 1;       // quotient bits resolved by the divider
    localparam int APB_DW   = (CW > 32) ? 64 : 32;
    localparam int ADDR_LSB = (CW > 32) ? 3 : 2;
    localparam int APB_AW   = ADDR_LSB + 2;

    typedef enum logic [1:0] {
        REG_X_SCALE      = 2'd0,
        REG_Y_SCALE      = 2'd1,
        REG_DEPTH_SCALE  = 2'd2,
        REG_DEPTH_OFFSET = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [NW-1:0] rem;
        logic [QB-1:0] q;
    } t_lane;

    typedef struct packed {
        logic          do_div;
        logic          wneg;
        logic [CW-1:0] d;
        t_lane [2:0]   lane;
    } t_item;

    // One restoring step: try the divisor shifted to quotient bit pos.
    function automatic t_item div_step(input t_item it, input int pos);
        t_item         r;
        logic [NW-1:0] sh;
        r  = it;
        sh = NW'(it.d) << pos;
        for (int l = 0; l < 3; l++) begin
            if (it.do_div && !it.lane[l].ovf && (it.lane[l].rem >= sh)) begin
                r.lane[l].rem    = it.lane[l].rem - sh;
                r.lane[l].q[pos] = 1'b1;
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/perspective_point_projection.sv -----
// Top level: pipelined perspective projection with perspective divide.
`timescale 1ns / 1ps
`default_nettype none
// Projects one signed fixed-point eye-space point per word. Clip values are
// x*x_scale, y*y_scale, z*depth_scale + depth_offset, kept exact; w = -z.
// When |w| is above the near-zero bound the three clip values are divided by
// w (truncated toward zero), otherwise they pass through truncated to the
// fraction width. Results saturate and tuser reports divided and clipped.
// Throughput is one point per cycle while the output is not stalled. The pipe
// has five front stages (operand split, multiply, offset add, magnitude,
// overflow precheck), one restoring divider stage per quotient bit
// (COORD_WIDTH + 1 of them) and the output register. The whole pipe
// advances together whenever the output register is empty or being taken.
// Registers are written over APB at byte address 4*i and read back likewise.
`include "perspective_point_projection_macros.svh"
module perspective_point_projection import ppp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // slave stream: tdata = point_x, point_y, point_z (lowest bits first)
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [3*CW-1:0]   i_s_tdata,
    // master stream: tdata = proj_x, proj_y, proj_z (lowest bits first)
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [3*CW-1:0]        o_m_tdata,
    // master tuser: divided, clipped (lowest bit first)
    output logic [1:0]             o_m_tuser,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);
    localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};

    // ---------------- configuration registers ----------------
    logic [CW-1:0] r_x_scale, r_y_scale, r_depth_scale, r_depth_offset;
    logic          cfg_wr;
    t_reg_idx      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:ADDR_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale      <= CW'(1) << FRAC_BITS;
            r_y_scale      <= CW'(1) << FRAC_BITS;
            r_depth_scale  <= CW'(0) - (CW'(1) << FRAC_BITS);
            r_depth_offset <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_X_SCALE:      r_x_scale      <= pwdata[CW-1:0];
                REG_Y_SCALE:      r_y_scale      <= pwdata[CW-1:0];
                REG_DEPTH_SCALE:  r_depth_scale  <= pwdata[CW-1:0];
                REG_DEPTH_OFFSET: r_depth_offset <= pwdata[CW-1:0];
                default:          r_x_scale      <= r_x_scale;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_X_SCALE:      prdata = APB_DW'(r_x_scale);
            REG_Y_SCALE:      prdata = APB_DW'(r_y_scale);
            REG_DEPTH_SCALE:  prdata = APB_DW'(r_depth_scale);
            REG_DEPTH_OFFSET: prdata = APB_DW'(r_depth_offset);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Advance every stage together while the output register can move.
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_out_valid;

    // ---------------- stage 1: split into sign and magnitude ----------------
    logic          r1_valid;
    logic [CW-1:0] r1_amag [3];
    logic [CW-1:0] r1_bmag [3];
    logic          r1_neg  [3];
    logic [CW-1:0] r1_omag;
    logic          r1_oneg, r1_do_div, r1_wneg;
    logic [CW-1:0] r1_d;
    logic [CW-1:0] pt   [3];
    logic [CW-1:0] coef [3];

    assign pt[0]   = i_s_tdata[CW-1:0];
    assign pt[1]   = i_s_tdata[2*CW-1:CW];
    assign pt[2]   = i_s_tdata[3*CW-1:2*CW];
    assign coef[0] = r_x_scale;
    assign coef[1] = r_y_scale;
    assign coef[2] = r_depth_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_s_tvalid;
        end
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r1_amag[l] <= pt[l][CW-1] ? CW'(0) - pt[l] : pt[l];
                r1_bmag[l] <= coef[l][CW-1] ? CW'(0) - coef[l] : coef[l];
                r1_neg[l]  <= pt[l][CW-1] ^ coef[l][CW-1];
            end
            r1_omag   <= r_depth_offset[CW-1] ? CW'(0) - r_depth_offset : r_depth_offset;
            r1_oneg   <= r_depth_offset[CW-1];
            r1_wneg   <= !pt[2][CW-1];
            r1_d      <= pt[2][CW-1] ? CW'(0) - pt[2] : pt[2];
            r1_do_div <= (pt[2][CW-1] ? CW'(0) - pt[2] : pt[2]) > CW'(W_EPS_LSB);
        end
    end

    // ---------------- stage 2: magnitude products ----------------
    logic            r2_valid;
    logic [2*CW-1:0] r2_pm  [3];
    logic            r2_neg [3];
    logic [CW-1:0]   r2_omag;
    logic            r2_oneg, r2_do_div, r2_wneg;
    logic [CW-1:0]   r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r2_pm[l]  <= (2*CW)'(r1_amag[l]) * (2*CW)'(r1_bmag[l]);
                r2_neg[l] <= r1_neg[l];
            end
            r2_omag   <= r1_omag;
            r2_oneg   <= r1_oneg;
            r2_do_div <= r1_do_div;
            r2_wneg   <= r1_wneg;
            r2_d      <= r1_d;
        end
    end

    // ---------------- stage 3: signed clip sum (offset on depth) ----------------
    logic                 r3_valid;
    logic signed [SW-1:0] r3_sum [3];
    logic                 r3_do_div, r3_wneg;
    logic [CW-1:0]        r3_d;
    logic signed [SW-1:0] n3_sum [3];
    logic signed [SW-1:0] off_term;

    always_comb begin
        off_term = $signed(SW'(r2_omag) << FRAC_BITS);
        if (r2_oneg) begin
            off_term = -off_term;
        end
        for (int l = 0; l < 3; l++) begin
            n3_sum[l] = r2_neg[l] ? -$signed(SW'(r2_pm[l])) : $signed(SW'(r2_pm[l]));
        end
        n3_sum[2] = n3_sum[2] + off_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
        if (en) begin
            r3_sum    <= n3_sum;
            r3_do_div <= r2_do_div;
            r3_wneg   <= r2_wneg;
            r3_d      <= r2_d;
        end
    end

    // ---------------- stage 4: back to sign and magnitude ----------------
    logic          r4_valid;
    logic [NW-1:0] r4_mag [3];
    logic          r4_neg [3];
    logic          r4_do_div, r4_wneg;
    logic [CW-1:0] r4_d;
    logic [SW-1:0] abs4 [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            abs4[l] = r3_sum[l][SW-1] ? SW'(-r3_sum[l]) : SW'(r3_sum[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r4_mag[l] <= abs4[l][NW-1:0];
                r4_neg[l] <= r3_sum[l][SW-1];
            end
            r4_do_div <= r3_do_div;
            r4_wneg   <= r3_wneg;
            r4_d      <= r3_d;
        end
    end

    // ---------------- stage 5: quotient overflow precheck ----------------
    // A quotient of 2^QB or more saturates on its own; drop it from the divider.
    t_item         n5_item;
    logic [NW-1:0] dtop;

    always_comb begin
        dtop              = NW'(r4_d) << QB;
        n5_item.do_div    = r4_do_div;
        n5_item.wneg      = r4_wneg;
        n5_item.d         = r4_d;
        for (int l = 0; l < 3; l++) begin
            n5_item.lane[l].neg = r4_neg[l];
            n5_item.lane[l].ovf = r4_do_div && (r4_mag[l] >= dtop);
            n5_item.lane[l].rem = r4_mag[l];
            n5_item.lane[l].q   = '0;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    t_item r_dv       [QB+1];
    logic  r_dv_valid [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= r4_valid;
        end
        if (en) begin
            r_dv[0] <= n5_item;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            if (en) begin
                r_dv[k+1] <= div_step(r_dv[k], QB - 1 - k);
            end
        end
    end

    // ---------------- output stage: saturate and register ----------------
    t_item         fin;
    logic [NW-1:0] mv   [3];
    logic [NW-1:0] lim  [3];
    logic          sat  [3];
    logic          rneg [3];
    logic [CW-1:0] res  [3];
    logic [CW-1:0] r_proj [3];
    logic          r_divided, r_clipped;

    assign fin = r_dv[QB];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            mv[l]   = fin.do_div ? NW'(fin.lane[l].q) : (fin.lane[l].rem >> FRAC_BITS);
            rneg[l] = fin.lane[l].neg ^ (fin.do_div && fin.wneg);
            lim[l]  = rneg[l] ? NW'(SMIN) : NW'(SMAX);
            sat[l]  = (fin.do_div && fin.lane[l].ovf) || (mv[l] > lim[l]);
            if (sat[l]) begin
                res[l] = rneg[l] ? SMIN : SMAX;
            end else begin
                res[l] = rneg[l] ? CW'(0) - mv[l][CW-1:0] : mv[l][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_valid[QB];
        end
        if (en) begin
            r_proj    <= res;
            r_divided <= fin.do_div;
            r_clipped <= sat[0] || sat[1] || sat[2];
        end
    end

    assign o_m_tdata = {r_proj[2], r_proj[1], r_proj[0]};
    assign o_m_tuser = {r_clipped, r_divided};

    // ---------------- assertions ----------------
    `PPP_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready, !o_s_tready)
    `PPP_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready, r1_valid)
    `PPP_ASSERT_NEXT(a_cfg_x_written, i_clk, i_rst_n,
        cfg_wr && cfg_idx == REG_X_SCALE, r_x_scale == $past(pwdata[CW-1:0]))
endmodule
`default_nettype wire

// ----- dv/tb_perspective_point_projection.sv -----
// Self-checking testbench for the perspective point projection block.
`timescale 1ns / 1ps
module tb_perspective_point_projection;
    import ppp_pkg::*;

    localparam int LATENCY     = CW + 7;
    localparam int CYCLE_LIMIT = 2000000;

    // Packed so that px sits in the lowest bits, matching tdata.
    typedef struct packed {
        logic [CW-1:0] pz;
        logic [CW-1:0] py;
        logic [CW-1:0] px;
    } t_point;

    typedef struct packed {
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
        logic          divided;
        logic          clipped;
    } t_proj;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [3*CW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [3*CW-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    perspective_point_projection dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the coefficient registers.
    logic signed [CW-1:0] x_scale_q, y_scale_q, depth_scale_q, depth_offset_q;

    t_point pending_points[$];
    t_proj  expected_proj[$];
    int     error_count = 0;
    int     cycle_count = 0;

    // Divide or truncate one exact clip value and clamp it to the coordinate range.
    function automatic logic [CW-1:0] finish_lane(input logic signed [2*CW+1:0] clip,
                                                  input logic do_div,
                                                  input logic signed [CW:0] w,
                                                  inout logic sat);
        logic signed [2*CW+1:0] q;
        logic signed [2*CW+1:0] maxv, minv;
        maxv = '0;
        maxv[CW-2:0] = '1;
        minv = '1;
        minv[CW-2:0] = '0;
        if (do_div) q = clip / (2*CW+2)'(w);     // truncates toward zero
        else q = (clip < 0) ? -((-clip) >>> FRAC_BITS) : (clip >>> FRAC_BITS);
        if (q > maxv) begin
            sat = 1'b1;
            return maxv[CW-1:0];
        end
        if (q < minv) begin
            sat = 1'b1;
            return minv[CW-1:0];
        end
        return q[CW-1:0];
    endfunction

    function automatic t_proj project_point(input t_point p);
        t_proj r;
        logic signed [2*CW+1:0] xc, yc, zc;
        logic signed [CW:0] w;
        logic do_div, sat;
        sat = 1'b0;
        xc = (2*CW+2)'($signed(p.px)) * (2*CW+2)'(x_scale_q);
        yc = (2*CW+2)'($signed(p.py)) * (2*CW+2)'(y_scale_q);
        zc = (2*CW+2)'($signed(p.pz)) * (2*CW+2)'(depth_scale_q)
             + ((2*CW+2)'(depth_offset_q) <<< FRAC_BITS);
        w = -(CW+1)'($signed(p.pz));
        do_div = ((w < 0) ? -w : w) > W_EPS_LSB;
        r.px = finish_lane(xc, do_div, w, sat);
        r.py = finish_lane(yc, do_div, w, sat);
        r.pz = finish_lane(zc, do_div, w, sat);
        r.divided = do_div;
        r.clipped = sat;
        return r;
    endfunction

    // Record input acceptance at the rising edge where it happens.
    logic s_fire = 1'b0;
    always @(posedge i_clk) begin
        s_fire <= i_rst_n && s_tvalid && s_tready;
    end

    // Driver: present pending points with random gaps.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_fire) begin
                expected_proj.push_back(project_point(t_point'(s_tdata)));
                void'(pending_points.pop_front());
            end
            if (s_tvalid && !s_fire) begin
                // hold the word
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_points[0];
                if ($urandom_range(0, 3) == 0)
                    send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                            : $urandom_range(1, 3);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, changed on the falling edge.
    int stall = 0;
    always @(negedge i_clk) begin
        if (stall > 0) begin
            stall <= stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80)
                                                     : $urandom_range(1, 3);
        end
    end

    // Monitor: compare each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_proj.size() == 0) begin
                $error("result word with no expectation: %h", m_tdata);
                error_count++;
            end else begin
                t_proj e;
                e = expected_proj.pop_front();
                if (m_tdata[CW-1:0] !== e.px) begin
                    $error("proj_x expected %h actual %h", e.px, m_tdata[CW-1:0]);
                    error_count++;
                end
                if (m_tdata[2*CW-1:CW] !== e.py) begin
                    $error("proj_y expected %h actual %h", e.py, m_tdata[2*CW-1:CW]);
                    error_count++;
                end
                if (m_tdata[3*CW-1:2*CW] !== e.pz) begin
                    $error("proj_z expected %h actual %h", e.pz, m_tdata[3*CW-1:2*CW]);
                    error_count++;
                end
                if (m_tuser[0] !== e.divided) begin
                    $error("divided expected %b actual %b", e.divided, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== e.clipped) begin
                    $error("clipped expected %b actual %b", e.clipped, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CW-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << ADDR_LSB; pwdata <= APB_DW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_X_SCALE:      x_scale_q      = val;
            REG_Y_SCALE:      y_scale_q      = val;
            REG_DEPTH_SCALE:  depth_scale_q  = val;
            REG_DEPTH_OFFSET: depth_offset_q = val;
        endcase
    endtask

    // Wait until the pipe is empty so registers can change safely.
    task automatic drain();
        while (pending_points.size() > 0 || s_tvalid || expected_proj.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return '0;
            3: return CW'($urandom_range(0, 8)) - 4;
            4: return CW'($signed(CW'($urandom_range(0, 1 << 20)) - (1 << 19)));
            default: return CW'($urandom());
        endcase
    endfunction

    task automatic add_point(input logic [CW-1:0] x, y, z);
        t_point p;
        p.px = x; p.py = y; p.pz = z;
        pending_points.push_back(p);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) add_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;

    initial begin
        x_scale_q = ONE; y_scale_q = ONE; depth_scale_q = -ONE; depth_offset_q = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset coefficients, zero w pass-through, extremes, saturation.
        add_point(ONE, ONE, -ONE);
        add_point(ONE, -ONE, '0);
        add_point(MAXC, MINC, '0);
        add_point(MAXC, MAXC, CW'(1));
        add_point(MINC, MINC, CW'(-1));
        add_point(MINC, MAXC, MINC);
        add_point(MAXC, MINC, MAXC);
        add_point('0, '0, CW'(1));
        add_point(CW'(12345), CW'(-777), CW'(3) << FRAC_BITS);
        drain();

        write_reg(REG_X_SCALE, MAXC);
        write_reg(REG_Y_SCALE, MINC);
        write_reg(REG_DEPTH_SCALE, MAXC);
        write_reg(REG_DEPTH_OFFSET, MINC);
        add_point(MAXC, MAXC, '0);
        add_point(MINC, MINC, MINC);
        add_point(CW'(1), CW'(-1), CW'(1));
        add_point(CW'(-1), CW'(1), MAXC);
        add_point('0, '0, '0);
        random_phase(300);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_X_SCALE, rand_coord());
            write_reg(REG_Y_SCALE, rand_coord());
            write_reg(REG_DEPTH_SCALE, rand_coord());
            write_reg(REG_DEPTH_OFFSET, rand_coord());
            random_phase(340);
            drain();
        end

        // Typical projection set-up: modest coefficients, most points divide in range.
        write_reg(REG_X_SCALE, CW'(98304));
        write_reg(REG_Y_SCALE, CW'(131072));
        write_reg(REG_DEPTH_SCALE, CW'(-67000));
        write_reg(REG_DEPTH_OFFSET, CW'(-13000));
        random_phase(200);
        drain();
        write_reg(REG_DEPTH_OFFSET, MAXC);
        write_reg(REG_DEPTH_SCALE, MINC);
        random_phase(100);
        drain();

        if (error_count == 0 && expected_proj.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
